### sv/abhi_pkg.sv
// ----------------------------------------------------------------------------
// abhi_pkg
// Shared constants and helpers of the Adams-Bashforth heat integrator.
// ----------------------------------------------------------------------------
package abhi_pkg;

  localparam int MaxMeshes = 1024;
  localparam int MeshW = 10;
  localparam int HistRows = 5;
  localparam int HistAw = 13;
  localparam logic [31:0] TimeStepReset = 32'd65536;

  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusZeroCap = 2'd1;
  localparam logic [1:0] StatusSat = 2'd2;

  // Signed Q4.28 weights, indexed by order and by age of the history row.
  function automatic logic signed [31:0] ab_coef(input logic [2:0] order,
                                                 input logic [2:0] age);
    logic signed [31:0] c;
    c = '0;
    case ({order, age})
      {3'd0, 3'd0}: c = 32'sd268435456;
      {3'd1, 3'd0}: c = 32'sd402653184;
      {3'd1, 3'd1}: c = -32'sd134217728;
      {3'd2, 3'd0}: c = 32'sd514501291;
      {3'd2, 3'd1}: c = -32'sd357913941;
      {3'd2, 3'd2}: c = 32'sd111848107;
      {3'd3, 3'd0}: c = 32'sd615164587;
      {3'd3, 3'd1}: c = -32'sd659903829;
      {3'd3, 3'd2}: c = 32'sd413837995;
      {3'd3, 3'd3}: c = -32'sd100663296;
      {3'd4, 3'd0}: c = 32'sd708744169;
      {3'd4, 3'd1}: c = -32'sd1034222160;
      {3'd4, 3'd2}: c = 32'sd975315490;
      {3'd4, 3'd3}: c = -32'sd474981626;
      {3'd4, 3'd4}: c = 32'sd93579583;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### sv/adams_bashforth_heat_integrator.sv
// ----------------------------------------------------------------------------
// adams_bashforth_heat_integrator
// Per-mesh temperature integration with a fifth-order Adams-Bashforth scheme.
// ----------------------------------------------------------------------------
// One item is processed at a time. A load item goes from acceptance through
// the write-back and result hand-off states back to idle. A step item first
// runs a 49-step restoring divider that forms the rate (one quotient bit a
// cycle), then reads one to five history rows from the history RAM and
// multiply-accumulates them one row at a time, then performs the weighted-sum
// rounding, the product with the time step, the write-back and the result
// hand-off. The result register is freed when taken, so the next request is
// accepted while a result waits.
// Temperatures live in a 1024-entry RAM, rate history in a 5120-entry RAM
// (row * 1024 + mesh); neither is cleared at reset.
module adams_bashforth_heat_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: mesh[9:0], start_temperature[41:10], absorbed_power[73:42],
  // emitted_power[105:74], heat_capacity[136:106], zero fill to 144
  input  logic [143:0] s_tdata,
  input  logic         s_tuser,  // kind
  input  logic         s_tlast,  // last_mesh
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: mesh_out[9:0], new_temperature[41:10], rate[73:42],
  // order_used[76:74], status[78:77], zero fill to 80
  output logic [79:0]  m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RATE, S_HRD, S_HACC, S_WSUM, S_MUL, S_DONE, S_OUT
  } state_t;

  state_t state;
  logic [31:0] time_step;

  // Latched request.
  logic        kind;
  logic [9:0]  mesh;
  logic signed [31:0] start_t;
  logic [30:0] cap;
  logic        last;

  // Step state.
  logic [2:0] step_order;
  logic [2:0] history_row;

  // Divider: magnitude of (a - e) << 16, 49 bits.
  logic [48:0] dividend;
  logic [47:0] quo;
  logic [31:0] rem;
  logic        neg;
  logic [5:0]  dcnt;

  logic signed [31:0] rate;
  logic signed [31:0] rate_calc;
  logic        rate_sat;
  logic        sat;
  logic [2:0]  age;
  logic signed [66:0] acc;
  logic signed [31:0] wsum;
  logic signed [31:0] temp_old;
  logic signed [31:0] temp_new;

  // Output register.
  logic [9:0]  o_mesh;
  logic [31:0] o_temp;
  logic [31:0] o_rate;
  logic [2:0]  o_order;
  logic [1:0]  o_status;

  // RAM ports.
  logic               t_we;
  logic [9:0]         t_addr;
  logic [31:0]        t_wdata;
  logic [31:0]        t_rdata;
  logic               h_we;
  logic [12:0]        h_addr;
  logic [31:0]        h_wdata;
  logic [31:0]        h_rdata;

  logic [2:0]  order;
  logic [2:0]  hrow_rd;
  logic [32:0] sub;
  logic signed [32:0] diff;
  logic signed [63:0] prod;
  logic signed [67:0] acc_r;
  logic signed [63:0] mul_ts;
  logic signed [48:0] delta;
  logic signed [49:0] tsum;

  abhi_ram #(.Width(32), .Depth(abhi_pkg::MaxMeshes)) u_temp (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  abhi_ram #(.Width(32), .Depth(abhi_pkg::MaxMeshes * abhi_pkg::HistRows)) u_hist (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign order     = (step_order > 3'd4) ? 3'd4 : step_order;
  assign m_tdata   = {1'b0, o_status, o_order, o_rate, o_temp, o_mesh};

  // Row read for the current age, modulo five.
  always_comb begin
    if (history_row >= age) begin
      hrow_rd = history_row - age;
    end else begin
      hrow_rd = history_row + 3'd5 - age;
    end
  end

  // Trial subtraction of the restoring divider.
  assign sub = {rem, dividend[48]} - {2'b0, cap};

  // Signed, saturated rate from the finished quotient; zero capacity gives 0.
  always_comb begin
    rate_sat  = 1'b0;
    rate_calc = neg ? 32'(-quo) : quo[31:0];
    if (cap == '0) begin
      rate_calc = '0;
    end else if (!neg && (quo > 48'h7FFFFFFF)) begin
      rate_calc = 32'sh7FFFFFFF;
      rate_sat  = 1'b1;
    end else if (neg && (quo > 48'h80000000)) begin
      rate_calc = 32'sh80000000;
      rate_sat  = 1'b1;
    end
  end

  // RAM addressing.
  always_comb begin
    t_we    = 1'b0;
    t_addr  = mesh;
    t_wdata = temp_new;
    h_we    = 1'b0;
    h_addr  = 13'(hrow_rd) * 13'(abhi_pkg::MaxMeshes) + 13'(mesh);
    h_wdata = rate;
    case (state)
      S_IDLE: begin
        t_addr = s_tdata[9:0];
      end
      S_RATE: begin
        h_we    = 1'b1;
        h_addr  = 13'(history_row) * 13'(abhi_pkg::MaxMeshes) + 13'(mesh);
        h_wdata = rate_calc;
      end
      S_DONE: begin
        t_we    = 1'b1;
        t_wdata = kind ? temp_new : start_t;
      end
      default: ;
    endcase
  end

  assign diff   = $signed({s_tdata[73], s_tdata[73:42]}) -
                  $signed({s_tdata[105], s_tdata[105:74]});
  assign prod   = $signed(h_rdata) * abhi_pkg::ab_coef(order, age - 3'd1);
  assign acc_r  = $signed({acc[66], acc}) + 68'sd134217728;
  assign mul_ts = $signed({wsum[31], wsum}) * $signed({1'b0, time_step});
  assign delta  = 49'(($signed({mul_ts[63], mul_ts}) + 65'sd32768) >>> 16);
  assign tsum   = $signed({{18{temp_old[31]}}, temp_old}) + $signed({delta[48], delta});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      time_step   <= abhi_pkg::TimeStepReset;
      step_order  <= '0;
      history_row <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_step <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            mesh    <= s_tdata[9:0];
            start_t <= s_tdata[41:10];
            cap     <= s_tdata[136:106];
            last    <= s_tlast;
            neg     <= diff[32];
            dividend <= {(diff[32] ? 33'(-diff) : 33'(diff)), 16'b0};
            rem     <= '0;
            quo     <= '0;
            dcnt    <= '0;
            sat     <= 1'b0;
            state   <= (s_tuser == abhi_pkg::KindLoad) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit a cycle.
          if (!sub[32]) begin
            rem <= sub[31:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= {rem[30:0], dividend[48]};
            quo <= {quo[46:0], 1'b0};
          end
          dividend <= {dividend[47:0], 1'b0};
          dcnt     <= dcnt + 6'd1;
          if (dcnt == 6'd48) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          // The 49th bit was shifted in above; quo holds the low 48 bits.
          temp_old <= t_rdata;
          rate     <= rate_calc;
          sat      <= rate_sat;
          age   <= '0;
          acc   <= '0;
          state <= S_HRD;
        end
        S_HRD: begin
          age   <= age + 3'd1;
          state <= S_HACC;
        end
        S_HACC: begin
          acc <= acc + 67'(prod);
          if (age > order) begin
            state <= S_WSUM;
          end else begin
            state <= S_HRD;
          end
        end
        S_WSUM: begin
          if ((acc_r >>> 28) > 68'sd2147483647) begin
            wsum <= 32'sh7FFFFFFF;
            sat  <= 1'b1;
          end else if ((acc_r >>> 28) < -68'sd2147483648) begin
            wsum <= 32'sh80000000;
            sat  <= 1'b1;
          end else begin
            wsum <= 32'(acc_r >>> 28);
          end
          state <= S_MUL;
        end
        S_MUL: begin
          if (tsum > 50'sd2147483647) begin
            temp_new <= 32'sh7FFFFFFF;
            sat      <= 1'b1;
          end else if (tsum < -50'sd2147483648) begin
            temp_new <= 32'sh80000000;
            sat      <= 1'b1;
          end else begin
            temp_new <= tsum[31:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_mesh   <= mesh;
            if (kind == abhi_pkg::KindLoad) begin
              o_temp   <= start_t;
              o_rate   <= '0;
              o_order  <= '0;
              o_status <= abhi_pkg::StatusOk;
            end else begin
              o_temp   <= temp_new;
              o_rate   <= rate;
              o_order  <= order;
              o_status <= (cap == '0) ? abhi_pkg::StatusZeroCap :
                          (sat ? abhi_pkg::StatusSat : abhi_pkg::StatusOk);
              if (last) begin
                history_row <= (history_row == 3'd4) ? 3'd0 : history_row + 3'd1;
                if (step_order < 3'd4) begin
                  step_order <= step_order + 3'd1;
                end
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/abhi_ram.sv
// ----------------------------------------------------------------------------
// abhi_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module abhi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
